### rtl/dqt_pkg.sv
// Shared types and constants for the delimiter and quote tokenizer.
`default_nettype none

package dqt_pkg;

    // Field widths
    localparam int BYTE_W = 8;
    localparam int OFF_W  = 16;
    localparam int MASK_W = 256;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 64;

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_DELIMITER_MODE = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_QUOTE_ENABLE   = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_DELIM_MASK_0   = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_DELIM_MASK_1   = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_DELIM_MASK_2   = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] CFG_DELIM_MASK_3   = 3'd5;

    // Characters with a special meaning
    localparam logic [BYTE_W-1:0] CHAR_NUL    = 8'h00;
    localparam logic [BYTE_W-1:0] CHAR_SQUOTE = 8'h27;
    localparam logic [BYTE_W-1:0] CHAR_DQUOTE = 8'h22;
    localparam logic [BYTE_W-1:0] CHAR_SPACE  = 8'h20;

    // Classification of one text byte
    typedef struct packed {
        logic sep;          // byte separates tokens
        logic quote_start;  // byte opens a quoted token
    } byte_class_t;

endpackage

`default_nettype wire

### rtl/delimiter_quote_tokenizer_top.sv
// Top level of the delimiter and quote tokenizer: scan state, descriptors, config port.
// A byte held in the input register has its descriptor loaded into the result register and put on m_tvalid
// once that register is free. Throughput: one byte per cycle; the input register and the result
// register each hold one beat, so s_tready drops only while a finished descriptor waits on m_tready.
// Reset (rst_n low, asynchronous): scan between tokens at offset zero, no beats held,
// whitespace mode with quotes enabled and an empty delimiter mask.
`default_nettype none

module delimiter_quote_tokenizer_top #(
    parameter longint unsigned MAX_TEXT_LEN = 65536
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    // Text stream
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    input  wire logic [7:0]                      s_tdata,   // [7:0] text_byte
    // Token descriptor stream
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    output logic [63:0]                          m_tdata,   // [15:0] token_offset,
                                                            // [31:16] token_length,
                                                            // [47:32] value_offset,
                                                            // [63:48] value_length
    output logic                                 m_tuser,   // [0] quoted
    output logic                                 m_tlast,
    // Configuration writes
    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic [dqt_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [dqt_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import dqt_pkg::*;

    localparam longint unsigned CAP_WIDE =
        (MAX_TEXT_LEN - 1 > 65535) ? 65535 : (MAX_TEXT_LEN - 1);
    localparam logic [OFF_W-1:0] POS_CAP = CAP_WIDE[OFF_W-1:0];

    typedef enum logic [1:0] {
        PH_BETWEEN = 2'd0,
        PH_PLAIN   = 2'd1,
        PH_QUOTED  = 2'd2
    } phase_t;

    // Configuration registers
    logic              delimiter_mode_reg;
    logic              quote_enable_reg;
    logic [MASK_W-1:0] delim_mask_reg;

    // Input register
    logic              in_valid_reg;
    logic [BYTE_W-1:0] in_byte_reg;

    // Scan state
    phase_t            phase_reg, phase_next;
    logic [BYTE_W-1:0] open_quote_reg, open_quote_next;
    logic [OFF_W-1:0]  position_reg, position_next;
    logic [OFF_W-1:0]  token_begin_reg, token_begin_next;

    // Result register
    logic              out_valid_reg;
    logic [OFF_W-1:0]  token_offset_reg, token_offset_next;
    logic [OFF_W-1:0]  token_length_reg, token_length_next;
    logic [OFF_W-1:0]  value_offset_reg, value_offset_next;
    logic [OFF_W-1:0]  value_length_reg, value_length_next;
    logic              quoted_reg, quoted_next;
    logic              last_reg, last_next;

    byte_class_t       byte_class;
    logic              emit;
    logic              advance;
    logic              out_free;
    logic              closed;
    logic [OFF_W:0]    raw_len;
    logic [OFF_W-1:0]  len;
    logic [OFF_W-1:0]  len_sat;
    logic [OFF_W-1:0]  strip;

    dqt_byte_class u_byte_class (
        .text_byte      (in_byte_reg),
        .delimiter_mode (delimiter_mode_reg),
        .quote_enable   (quote_enable_reg),
        .delim_mask     (delim_mask_reg),
        .byte_class     (byte_class)
    );

    // Handshakes
    assign cfg_ready = 1'b1;
    assign out_free  = !out_valid_reg || m_tready;
    assign advance   = in_valid_reg && (!emit || out_free);
    assign s_tready  = !in_valid_reg || advance;

    assign len = position_reg - token_begin_reg;

    // Scan step: next phase and the descriptor this byte completes
    always_comb
    begin
        phase_next       = phase_reg;
        open_quote_next  = open_quote_reg;
        token_begin_next = token_begin_reg;
        position_next    = (position_reg < POS_CAP) ? position_reg + 16'd1 : position_reg;
        emit             = 1'b0;
        raw_len          = {1'b0, len};
        closed           = 1'b0;
        quoted_next      = 1'b0;
        last_next        = 1'b0;
        token_offset_next = token_begin_reg;

        if (in_byte_reg == CHAR_NUL) begin
            emit      = 1'b1;
            last_next = 1'b1;
            case (phase_reg)
                PH_PLAIN:
                begin
                    raw_len = {1'b0, len};
                end
                PH_QUOTED:
                begin
                    raw_len     = {1'b0, len};
                    quoted_next = 1'b1;
                end
                default:
                begin
                    token_offset_next = position_reg;
                    raw_len           = '0;
                end
            endcase
            phase_next       = PH_BETWEEN;
            open_quote_next  = CHAR_NUL;
            position_next    = '0;
            token_begin_next = '0;
        end else begin
            case (phase_reg)
                PH_PLAIN:
                begin
                    // End the token at a separator
                    if (byte_class.sep) begin
                        emit       = 1'b1;
                        phase_next = PH_BETWEEN;
                    end
                end
                PH_QUOTED:
                begin
                    // Close on the matching quote, quote included
                    if (in_byte_reg == open_quote_reg) begin
                        emit            = 1'b1;
                        raw_len         = {1'b0, len} + 17'd1;
                        closed          = 1'b1;
                        quoted_next     = 1'b1;
                        phase_next      = PH_BETWEEN;
                        open_quote_next = CHAR_NUL;
                    end
                end
                default:
                begin
                    // Start a token at any non-separator
                    if (!byte_class.sep) begin
                        token_begin_next = position_reg;
                        if (byte_class.quote_start) begin
                            phase_next      = PH_QUOTED;
                            open_quote_next = in_byte_reg;
                        end else begin
                            phase_next = PH_PLAIN;
                        end
                    end
                end
            endcase
        end

        // Saturate lengths and strip quotes from the value span
        len_sat = raw_len[OFF_W] ? {OFF_W{1'b1}} : raw_len[OFF_W-1:0];
        strip   = closed ? 16'd2 : 16'd1;
        token_length_next = len_sat;
        if (quoted_next) begin
            value_length_next = (len_sat > strip) ? len_sat - strip : '0;
            value_offset_next = (token_offset_next == POS_CAP) ? POS_CAP
                                                               : token_offset_next + 16'd1;
        end else begin
            value_length_next = len_sat;
            value_offset_next = token_offset_next;
        end
    end

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            delimiter_mode_reg <= 1'b0;
            quote_enable_reg   <= 1'b1;
            delim_mask_reg     <= '0;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                CFG_DELIMITER_MODE: delimiter_mode_reg     <= cfg_data[0];
                CFG_QUOTE_ENABLE:   quote_enable_reg       <= cfg_data[0];
                CFG_DELIM_MASK_0:   delim_mask_reg[63:0]   <= cfg_data;
                CFG_DELIM_MASK_1:   delim_mask_reg[127:64] <= cfg_data;
                CFG_DELIM_MASK_2:   delim_mask_reg[191:128] <= cfg_data;
                CFG_DELIM_MASK_3:   delim_mask_reg[255:192] <= cfg_data;
                default: ;
            endcase
        end
    end

    // Input register, scan state and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            in_valid_reg    <= 1'b0;
            phase_reg       <= PH_BETWEEN;
            open_quote_reg  <= CHAR_NUL;
            position_reg    <= '0;
            token_begin_reg <= '0;
            out_valid_reg   <= 1'b0;
        end else begin
            // Hold or take the next text beat
            if (s_tvalid && s_tready) begin
                in_valid_reg <= 1'b1;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end

            // Advance the scan
            if (advance) begin
                phase_reg       <= phase_next;
                open_quote_reg  <= open_quote_next;
                position_reg    <= position_next;
                token_begin_reg <= token_begin_next;
            end

            // Load or drop the descriptor beat
            if (advance && emit) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready) begin
            in_byte_reg <= s_tdata;
        end
        if (advance && emit) begin
            token_offset_reg <= token_offset_next;
            token_length_reg <= token_length_next;
            value_offset_reg <= value_offset_next;
            value_length_reg <= value_length_next;
            quoted_reg       <= quoted_next;
            last_reg         <= last_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {value_length_reg, value_offset_reg, token_length_reg, token_offset_reg};
    assign m_tuser  = quoted_reg;
    assign m_tlast  = last_reg;

`ifndef ASSERT_OFF
    a_position_capped: assert property (@(posedge clk) disable iff (!rst_n)
        position_reg <= POS_CAP)
        else $error("position beyond cap");

    a_begin_not_ahead: assert property (@(posedge clk) disable iff (!rst_n)
        token_begin_reg <= position_reg)
        else $error("token start ahead of position");

    a_quote_held: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_QUOTED |->
            (open_quote_reg == CHAR_SQUOTE || open_quote_reg == CHAR_DQUOTE))
        else $error("quoted token without an open quote");

    a_plain_span: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !quoted_reg |->
            (value_offset_reg == token_offset_reg && value_length_reg == token_length_reg))
        else $error("plain token value span differs from token span");

    a_restart_after_end: assert property (@(posedge clk) disable iff (!rst_n)
        advance && in_byte_reg == CHAR_NUL |=> position_reg == '0 && phase_reg == PH_BETWEEN)
        else $error("scan not restarted after end of text");
`endif

endmodule

`default_nettype wire

### rtl/dqt_byte_class.sv
// Byte classifier: separator test and quote detection for one text byte.
`default_nettype none

module dqt_byte_class (
    input  wire logic [dqt_pkg::BYTE_W-1:0] text_byte,
    input  wire logic                       delimiter_mode,
    input  wire logic                       quote_enable,
    input  wire logic [dqt_pkg::MASK_W-1:0] delim_mask,
    output dqt_pkg::byte_class_t            byte_class
);
    import dqt_pkg::*;

    logic mask_in_use;
    logic white_space;

    // Use the mask only in delimiter mode and only when some bit past zero is set
    assign mask_in_use = delimiter_mode && (|delim_mask[MASK_W-1:1]);

    always_comb
    begin
        white_space = (text_byte == CHAR_SPACE) || (text_byte inside {[8'd9:8'd13]});
    end

    always_comb
    begin
        byte_class.sep         = mask_in_use ? delim_mask[text_byte] : white_space;
        byte_class.quote_start = !delimiter_mode && quote_enable &&
                                 ((text_byte == CHAR_SQUOTE) || (text_byte == CHAR_DQUOTE));
    end

endmodule

`default_nettype wire

### dv/tb_top.sv
// Testbench for the delimiter and quote tokenizer: text byte stream in, token descriptors out.
`timescale 1ns / 1ps

module tb_top;

    import dqt_pkg::*;

    localparam int unsigned POS_LIMIT      = 65535;  // smaller of MAX_TEXT_LEN - 1 and 65535
    localparam int unsigned LEN_LIMIT      = 65535;
    localparam int unsigned SETTLE_CYCLES  = 4;      // margin after the queues drain
    localparam int unsigned LONG_HOLD      = 300;
    localparam int unsigned HOLD_AFTER     = 40;
    localparam int unsigned WATCHDOG_LIMIT = 2000;
    localparam int unsigned RANDOM_PHASES  = 10;
    localparam int unsigned PHASE_BYTES    = 56;

    localparam logic [7:0] CHAR_TAB = 8'h09;
    localparam logic [7:0] CHAR_CR  = 8'h0D;
    localparam logic [7:0] CHAR_LOW = 8'h61;
    localparam logic [7:0] CHAR_Z   = 8'h7A;

    typedef enum logic [1:0] {
        SCAN_GAP    = 2'd0,
        SCAN_PLAIN  = 2'd1,
        SCAN_QUOTED = 2'd2
    } scan_state_t;

    typedef struct packed {
        logic [15:0] tok_off;
        logic [15:0] tok_len;
        logic [15:0] val_off;
        logic [15:0] val_len;
        logic        quoted;
        logic        last;
    } token_desc_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [63:0] m_tdata;
    logic        m_tuser;
    logic        m_tlast;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;

    // Tokenizer shadow: configuration and scan state
    logic          cfg_delim_mode = 1'b0;
    logic          cfg_quote_en = 1'b1;
    logic [255:0]  delim_bits = '0;
    scan_state_t   scan_state = SCAN_GAP;
    logic [7:0]    quote_char = CHAR_NUL;
    int unsigned   text_pos = 0;
    int unsigned   tok_start = 0;

    logic [7:0]    text_queue[$];
    token_desc_t   pending_desc[$];
    int unsigned   bytes_queued = 0;
    int unsigned   error_count = 0;
    int unsigned   idle_cycles = 0;
    int unsigned   burst_left = 0;
    int unsigned   gap_left = 0;
    int unsigned   hold_left = 0;
    bit            hold_done = 1'b0;
    int unsigned   desc_beats = 0;
    int unsigned   ready_mode = 0;
    int unsigned   mode_left = 0;
    token_desc_t   predicted;
    token_desc_t   want;

    delimiter_quote_tokenizer_top uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Separator classification under the current registers
    function automatic bit mask_active();
        return cfg_delim_mode && (delim_bits[255:1] != '0);
    endfunction

    function automatic bit is_separator(input logic [7:0] b);
        if (mask_active())
            return delim_bits[b];
        return b == CHAR_SPACE || (b >= CHAR_TAB && b <= CHAR_CR);
    endfunction

    // Build one descriptor from the current token start
    function automatic token_desc_t make_desc(input int unsigned raw_len, input bit is_quoted,
                                              input bit closed, input bit at_end);
        token_desc_t d;
        int unsigned off;
        int unsigned len;
        int unsigned strip;
        off = (tok_start > POS_LIMIT) ? POS_LIMIT : tok_start;
        len = (raw_len > LEN_LIMIT) ? LEN_LIMIT : raw_len;
        strip = closed ? 2 : 1;
        d.tok_off = 16'(off);
        d.tok_len = 16'(len);
        if (is_quoted)
        begin
            d.val_off = 16'((off + 1 > POS_LIMIT) ? POS_LIMIT : off + 1);
            d.val_len = 16'((len > strip) ? len - strip : 0);
        end
        else
        begin
            d.val_off = 16'(off);
            d.val_len = 16'(len);
        end
        d.quoted = is_quoted;
        d.last = at_end;
        return d;
    endfunction

    // Advance the scan by one byte; return 1 when the byte completes a descriptor
    function automatic bit tokenize_byte(input logic [7:0] b, output token_desc_t d);
        int unsigned span;
        bit made;
        span = (text_pos >= tok_start) ? text_pos - tok_start : 0;
        made = 1'b0;
        d = '0;
        if (b == CHAR_NUL)
        begin
            if (scan_state == SCAN_GAP)
            begin
                tok_start = text_pos;
                d = make_desc(0, 1'b0, 1'b0, 1'b1);
            end
            else
                d = make_desc(span, scan_state == SCAN_QUOTED, 1'b0, 1'b1);
            scan_state = SCAN_GAP;
            quote_char = CHAR_NUL;
            text_pos = 0;
            tok_start = 0;
            return 1'b1;
        end
        case (scan_state)
            SCAN_GAP:
                if (!is_separator(b))
                begin
                    tok_start = text_pos;
                    if (!cfg_delim_mode && cfg_quote_en &&
                        (b == CHAR_SQUOTE || b == CHAR_DQUOTE))
                    begin
                        scan_state = SCAN_QUOTED;
                        quote_char = b;
                    end
                    else
                        scan_state = SCAN_PLAIN;
                end
            SCAN_PLAIN:
                if (is_separator(b))
                begin
                    d = make_desc(span, 1'b0, 1'b0, 1'b0);
                    scan_state = SCAN_GAP;
                    made = 1'b1;
                end
            default:
                if (b == quote_char)
                begin
                    d = make_desc(span + 1, 1'b1, 1'b1, 1'b0);
                    scan_state = SCAN_GAP;
                    quote_char = CHAR_NUL;
                    made = 1'b1;
                end
        endcase
        if (text_pos < POS_LIMIT)
            text_pos++;
        return made;
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint exp_val);
        $display("MISMATCH %s: got %0d, expected %0d at %0t", what, got, exp_val, $realtime);
        error_count++;
    endtask

    // Sender: bursts of random length separated by random gaps
    always @(posedge clk)
    begin
        if (!rst_n)
            s_tvalid <= 1'b0;
        else
        begin
            if (s_tvalid && s_tready)
                text_queue.delete(0);
            if (!(s_tvalid && !s_tready))
            begin
                if (gap_left != 0)
                begin
                    gap_left--;
                    s_tvalid <= 1'b0;
                end
                else if (text_queue.size() != 0)
                begin
                    s_tvalid <= 1'b1;
                    s_tdata <= text_queue[0];
                    if (burst_left <= 1)
                    begin
                        burst_left = ($urandom_range(0, 7) == 0) ? 200 : $urandom_range(1, 24);
                        gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                    end
                    else
                        burst_left--;
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // Receiver: changing stall pattern, plus one long hold-off
    always @(posedge clk)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else
        begin
            if (m_tvalid && m_tready)
                desc_beats++;
            if (hold_left != 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else if (!hold_done && desc_beats >= HOLD_AFTER)
            begin
                hold_done = 1'b1;
                hold_left = LONG_HOLD;
                m_tready <= 1'b0;
            end
            else
            begin
                if (mode_left == 0)
                begin
                    ready_mode = $urandom_range(0, 3);
                    mode_left = $urandom_range(16, 96);
                end
                else
                    mode_left--;
                case (ready_mode)
                    0: m_tready <= 1'b1;
                    1: m_tready <= ($urandom_range(0, 3) != 0);
                    2: m_tready <= ($urandom_range(0, 3) == 0);
                    default: m_tready <= mode_left[1];
                endcase
            end
        end
    end

    // Monitor: predict on accepted bytes, check accepted descriptors
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
                if (tokenize_byte(s_tdata, predicted))
                    pending_desc.push_back(predicted);
            if (m_tvalid && m_tready)
            begin
                if (pending_desc.size() == 0)
                    report_mismatch("unexpected descriptor, token_offset", m_tdata[15:0], 0);
                else
                begin
                    want = pending_desc.pop_front();
                    if (m_tdata[15:0] != want.tok_off)
                        report_mismatch("token_offset", m_tdata[15:0], want.tok_off);
                    if (m_tdata[31:16] != want.tok_len)
                        report_mismatch("token_length", m_tdata[31:16], want.tok_len);
                    if (m_tdata[47:32] != want.val_off)
                        report_mismatch("value_offset", m_tdata[47:32], want.val_off);
                    if (m_tdata[63:48] != want.val_len)
                        report_mismatch("value_length", m_tdata[63:48], want.val_len);
                    if (m_tuser != want.quoted)
                        report_mismatch("quoted", m_tuser, want.quoted);
                    if (m_tlast != want.last)
                        report_mismatch("last", m_tlast, want.last);
                end
            end
        end
    end

    // Watchdog: end the run after too long without any beat
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [63:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_DELIMITER_MODE: cfg_delim_mode = val[0];
            CFG_QUOTE_ENABLE:   cfg_quote_en = val[0];
            CFG_DELIM_MASK_0:   delim_bits[63:0] = val;
            CFG_DELIM_MASK_1:   delim_bits[127:64] = val;
            CFG_DELIM_MASK_2:   delim_bits[191:128] = val;
            CFG_DELIM_MASK_3:   delim_bits[255:192] = val;
            default: ;
        endcase
    endtask

    // Wait until every byte is taken and every descriptor has arrived
    task automatic wait_idle();
        do @(posedge clk);
        while (text_queue.size() != 0 || s_tvalid || pending_desc.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic put(input logic [7:0] b);
        text_queue.push_back(b);
        bytes_queued++;
    endtask

    task automatic put_str(input string s, input bit terminate);
        for (int i = 0; i < s.len(); i++)
            put(s[i]);
        if (terminate)
            put(CHAR_NUL);
    endtask

    // Mostly letters that do not separate tokens under the current registers
    function automatic logic [7:0] word_byte();
        logic [7:0] b;
        b = CHAR_LOW;
        for (int i = 0; i < 32; i++)
        begin
            b = ($urandom_range(0, 3) != 0) ? 8'($urandom_range(CHAR_LOW, CHAR_Z))
                                            : 8'($urandom_range(1, 255));
            if (!is_separator(b))
                return b;
        end
        return b;
    endfunction

    function automatic logic [7:0] sep_byte();
        logic [7:0] b;
        if (!mask_active())
            return ($urandom_range(0, 1) != 0) ? CHAR_SPACE : 8'($urandom_range(CHAR_TAB, CHAR_CR));
        for (int i = 0; i < 64; i++)
        begin
            b = 8'($urandom_range(1, 255));
            if (is_separator(b))
                return b;
        end
        return CHAR_SPACE;
    endfunction

    function automatic logic [63:0] random_mask();
        logic [63:0] m;
        m = '0;
        case ($urandom_range(0, 5))
            0: m = '0;
            1: m = '1;
            2: m = {$urandom, $urandom};
            default:
                repeat ($urandom_range(1, 4))
                    m[$urandom_range(0, 63)] = 1'b1;
        endcase
        return m;
    endfunction

    task automatic random_config();
        write_reg(CFG_DELIMITER_MODE, 64'($urandom_range(0, 1)));
        write_reg(CFG_QUOTE_ENABLE, 64'($urandom_range(0, 1)));
        for (int k = 0; k < 4; k++)
            if ($urandom_range(0, 3) != 0)
                write_reg(CFG_INDEX_W'(CFG_DELIM_MASK_0 + k), random_mask());
    endtask

    // Queue texts: mostly well-formed token sequences, some raw noise
    task automatic gen_phase(input int unsigned budget);
        int unsigned start;
        logic [7:0] q;
        start = bytes_queued;
        while (bytes_queued - start < budget)
        begin
            if ($urandom_range(0, 7) == 0)
            begin
                repeat ($urandom_range(1, 16))
                    put(8'($urandom_range(0, 255)));
            end
            else
            begin
                repeat ($urandom_range(0, 6))
                begin
                    repeat ($urandom_range(0, 2))
                        put(sep_byte());
                    if ($urandom_range(0, 2) == 0)
                    begin
                        q = ($urandom_range(0, 1) != 0) ? CHAR_SQUOTE : CHAR_DQUOTE;
                        put(q);
                        repeat ($urandom_range(0, 6))
                            put(word_byte());
                        if ($urandom_range(0, 6) != 0)
                            put(q);
                    end
                    else
                        repeat ($urandom_range(1, 8))
                            put(word_byte());
                end
                repeat ($urandom_range(0, 2))
                    put(sep_byte());
            end
            put(CHAR_NUL);
        end
        // leave a token open across the next register change now and then
        if ($urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 3))
                put(word_byte());
    endtask

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // White space with quotes: separators, quoted and adjacent tokens, ends of text
        write_reg(CFG_DELIMITER_MODE, 64'd0);
        write_reg(CFG_QUOTE_ENABLE, 64'd1);
        write_reg(CFG_DELIM_MASK_0, 64'd0);
        write_reg(CFG_DELIM_MASK_1, 64'd0);
        write_reg(CFG_DELIM_MASK_2, 64'd0);
        write_reg(CFG_DELIM_MASK_3, 64'd0);
        put_str(" a", 1'b0);
        put(8'hFF);
        put_str("\t'x '\"\"b\r\n\v\f", 1'b0);
        put(8'h01);
        put(8'h80);
        put_str("c", 1'b1);
        put(CHAR_NUL);
        put_str("'", 1'b1);
        put_str("\"q'", 1'b1);
        wait_idle();

        // Quotes off: quote is an ordinary byte
        write_reg(CFG_QUOTE_ENABLE, 64'd0);
        put_str("'a b'", 1'b1);
        wait_idle();

        // Delimiter mode with only bit zero set behaves as white space
        write_reg(CFG_QUOTE_ENABLE, 64'd1);
        write_reg(CFG_DELIMITER_MODE, 64'd1);
        write_reg(CFG_DELIM_MASK_0, 64'd1);
        put_str("'x y", 1'b1);
        wait_idle();

        // Real mask: comma, colon and byte 255; quotes and space are plain bytes
        write_reg(CFG_DELIM_MASK_0, (64'd1 << 44) | (64'd1 << 58) | 64'd1);
        write_reg(CFG_DELIM_MASK_3, 64'd1 << 63);
        put_str("a,b::' c'", 1'b0);
        put(8'hFF);
        put_str("d", 1'b1);
        wait_idle();

        // Register change inside a quoted token, then inside a plain token
        write_reg(CFG_DELIMITER_MODE, 64'd0);
        put_str("x '", 1'b0);
        wait_idle();
        write_reg(CFG_DELIMITER_MODE, 64'd1);
        put_str("q'r,pq", 1'b0);
        wait_idle();
        write_reg(CFG_DELIMITER_MODE, 64'd0);
        put_str("r s", 1'b1);
        wait_idle();

        // Every byte a delimiter: only the empty closing descriptor
        write_reg(CFG_DELIMITER_MODE, 64'd1);
        write_reg(CFG_DELIM_MASK_0, '1);
        write_reg(CFG_DELIM_MASK_1, '1);
        write_reg(CFG_DELIM_MASK_2, '1);
        write_reg(CFG_DELIM_MASK_3, '1);
        put_str("a b", 1'b1);
        wait_idle();

        // Random settings and texts
        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            random_config();
            gen_phase(PHASE_BYTES);
            wait_idle();
        end

        repeat (SETTLE_CYCLES) @(posedge clk);
        if (error_count == 0 && pending_desc.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
